[rtl/core/box_downsample_2x2_core_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef BOX_DOWNSAMPLE_2X2_CORE_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BD2_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bd2 check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define BD2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bd2 check failed: next-cycle rule");

`endif

[rtl/core/bd2_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bd2_pkg;

	localparam int PIXEL_W = 8;
	localparam int PAIR_W = 9;
	localparam int WIDTH_CFG_W = 11;
	localparam int HEIGHT_CFG_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef struct packed {
		logic emit;
		logic use_line;
		logic frame_end;
	} bd2_ctl_t;

endpackage

`default_nettype wire

[rtl/core/bd2_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module bd2_line_store #(
	parameter int DEPTH = 512,
	parameter int ADDR_W = 9
) (
	input  wire                          clk,
	input  wire                          en,
	input  wire                          we,
	input  wire  [ADDR_W-1:0]            addr,
	input  wire  [bd2_pkg::PAIR_W-1:0]   wr_data,
	output logic [bd2_pkg::PAIR_W-1:0]   rd_data_s1
);
	import bd2_pkg::*;

	logic [PAIR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wr_data;
			end
			rd_data_s1 <= mem[addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/bd2_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module bd2_scan #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int ADDR_W = 9
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr,
	input  wire  [bd2_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [bd2_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                              accept,
	input  wire  [bd2_pkg::PIXEL_W-1:0]      pixel,
	output bd2_pkg::bd2_ctl_t                ctl,
	output logic [bd2_pkg::PAIR_W-1:0]       pair,
	output logic                             line_we,
	output logic [ADDR_W-1:0]                line_addr
);
	import bd2_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [WIDTH_CFG_W-1:0]  width_q;
	logic [HEIGHT_CFG_W-1:0] height_q;
	logic [CW-1:0]           x_q;
	logic [RW-1:0]           y_q;
	logic [PIXEL_W-1:0]      left_q;
	logic [31:0]             eff_w;
	logic [31:0]             eff_h;
	logic [CW-1:0]           last_x;
	logic [RW-1:0]           last_y;
	logic                    last_col;
	logic                    last_row;
	logic                    pair_done;

	always_comb begin
		if (width_q == '0) begin
			eff_w = 32'd1;
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = MAX_WIDTH;
		end else begin
			eff_w = 32'(width_q);
		end
		if (height_q == '0) begin
			eff_h = 32'd1;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = MAX_HEIGHT;
		end else begin
			eff_h = 32'(height_q);
		end
	end

	assign last_x = CW'(eff_w - 32'd1);
	assign last_y = RW'(eff_h - 32'd1);
	assign last_col = (x_q == last_x);
	assign last_row = (y_q == last_y);
	assign pair_done = x_q[0] | last_col;

	assign pair = x_q[0] ? ({1'b0, left_q} + {1'b0, pixel}) : {1'b0, pixel};

	assign ctl.emit = pair_done & (y_q[0] | last_row);
	assign ctl.use_line = y_q[0];
	assign ctl.frame_end = last_col & last_row;

	assign line_we = pair_done & ~y_q[0] & ~last_row;
	assign line_addr = ADDR_W'(x_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			x_q <= '0;
			y_q <= '0;
			left_q <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[WIDTH_CFG_W-1:0];
				x_q <= '0;
				y_q <= '0;
				left_q <= '0;
			end else if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[HEIGHT_CFG_W-1:0];
				x_q <= '0;
				y_q <= '0;
				left_q <= '0;
			end
		end else if (accept) begin
			if (!x_q[0]) begin
				left_q <= pixel;
			end
			if (last_col) begin
				x_q <= '0;
				y_q <= last_row ? '0 : y_q + RW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/bd2_combine.sv]
`timescale 1ns / 1ps
`default_nettype none

module bd2_combine (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            accept,
	input  wire bd2_pkg::bd2_ctl_t         ctl,
	input  wire  [bd2_pkg::PAIR_W-1:0]     pair,
	input  wire  [bd2_pkg::PAIR_W-1:0]     line_data_s1,
	output logic                           in_stall,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [bd2_pkg::PIXEL_W-1:0]    mean_pixel,
	output logic                           frame_end
);
	import bd2_pkg::*;

	logic                 valid_s1;
	bd2_ctl_t             ctl_s1;
	logic [PAIR_W-1:0]    pair_s1;
	logic                 advance;
	logic [PAIR_W:0]      sum;

	assign advance = valid_s1 & (~out_valid | ~out_stall);
	assign in_stall = valid_s1 & out_valid & out_stall;

	assign sum = ctl_s1.use_line ? ({1'b0, line_data_s1} + {1'b0, pair_s1})
	                             : {1'b0, pair_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= ctl.emit;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
			pair_s1 <= pair;
		end
		if (advance) begin
			mean_pixel <= sum[PAIR_W:2];
			frame_end <= ctl_s1.frame_end;
		end
	end

endmodule

`default_nettype wire

[rtl/core/box_downsample_2x2_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming 2x2 box downsampler for 8-bit grey images. Pixels enter in raster
// order, one per clock at full rate unless stalled, and each 2x2 block yields
// one output pixel, its truncated mean, with pixels past an odd right or bottom
// edge taken as zero. A result passes through the s1 and output registers after
// the transaction that completes its block; the single-port line store, touched
// once per pixel, sets the rate of one pixel per clock unless stalled. Writing
// either size register restarts the frame, and frame_end marks the last output
// pixel of each reduced image. The line store needs no clearing pass.
module box_downsample_2x2_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [bd2_pkg::PIXEL_W-1:0]      pixel,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [bd2_pkg::PIXEL_W-1:0]      mean_pixel,
	output logic                             frame_end,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [bd2_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [bd2_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bd2_pkg::*;

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic                 in_acc;
	logic                 cfg_wr;
	bd2_ctl_t             ctl;
	logic [PAIR_W-1:0]    pair;
	logic                 line_we;
	logic [ADDR_W-1:0]    line_addr;
	logic [PAIR_W-1:0]    line_data_s1;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;
	assign in_acc = in_valid & ~in_stall;

	bd2_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.ADDR_W     (ADDR_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (in_acc),
		.pixel     (pixel),
		.ctl       (ctl),
		.pair      (pair),
		.line_we   (line_we),
		.line_addr (line_addr)
	);

	bd2_line_store #(
		.DEPTH  (LINE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_line (
		.clk        (clk),
		.en         (in_acc),
		.we         (line_we),
		.addr       (line_addr),
		.wr_data    (pair),
		.rd_data_s1 (line_data_s1)
	);

	bd2_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.ctl          (ctl),
		.pair         (pair),
		.line_data_s1 (line_data_s1),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_pixel   (mean_pixel),
		.frame_end    (frame_end)
	);

endmodule

`default_nettype wire

[rtl/core/bd2_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "box_downsample_2x2_core_macros.svh"

module bd2_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_stall,
	input wire  [bd2_pkg::PIXEL_W-1:0]      pixel,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire  [bd2_pkg::PIXEL_W-1:0]      mean_pixel,
	input wire                              frame_end
);
	import bd2_pkg::*;

	// A stalled result transaction keeps its payload.
	`BD2_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(mean_pixel) && $stable(frame_end))

	// A stalled input transaction keeps its payload.
	`BD2_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(pixel))

	// The input side is held back only while a result waits at the output.
	`BD2_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// Back pressure persists as long as the output stays stalled.
	`BD2_ASSERT_NEXT(a_stall_keep, clk, arst_n, in_stall && out_stall, in_stall || !out_stall)

endmodule

bind box_downsample_2x2_core bd2_checker u_bd2_checker (.*);

`default_nettype wire
